/* hw/rtl/artdmx_pkg.sv */
// ----------------------------------------------------------------------------
// artdmx_pkg
// Shared types and constants of the ArtDmx packet receiver.
// ----------------------------------------------------------------------------
package artdmx_pkg;

    // Default packet store size in bytes
    localparam int STORE_BYTES_DEF = 530;
    // Store address of DMX slot 0 (slot 1 is the first channel)
    localparam int SLOT_OFFSET     = 17;

    // Header bytes mirrored in flops, and store addresses of the fields used
    localparam int HDR_BYTES   = 18;
    localparam int VERS_BYTE   = 11;
    localparam int UNIV_FIELD  = 14;
    localparam int LENH_BYTE   = 16;
    localparam int LENL_BYTE   = 17;
    localparam int ADDR_NET    = 102;
    localparam int ADDR_UNIV   = 98;
    localparam int ADDR_CMD    = 107;
    localparam int WIPE_FROM   = 18;

    // Minimum lengths and version
    localparam int DMX_HDR_LEN  = 18;
    localparam int ADDR_MIN_LEN = 108;
    localparam int POLL_MIN_LEN = 14;
    localparam logic [7:0] VERSION_MIN = 8'd14;

    // Packet identifier "Art-Net" plus a zero byte, first byte in the top bits
    localparam logic [63:0] ART_ID = 64'h4172_742D_4E65_7400;

    // Opcodes
    localparam logic [15:0] OP_NONE    = 16'h0000;
    localparam logic [15:0] OP_POLL    = 16'h2000;
    localparam logic [15:0] OP_DMX     = 16'h5000;
    localparam logic [15:0] OP_ADDRESS = 16'h6000;

    // ArtAddress commands and the "no change" nibble byte
    localparam logic [7:0] CMD_UNLOCK = 8'h01;
    localparam logic [7:0] CMD_CLEAR  = 8'h90;
    localparam logic [7:0] NIB_KEEP   = 8'h7f;

    // Slot count after a clear-levels command
    localparam logic [9:0] SLOTS_FULL = 10'd512;

    // Request and result kinds
    localparam logic REQ_BYTE     = 1'b0;
    localparam logic REQ_SLOT     = 1'b1;
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_SLOT    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  packet_byte;
        logic        last_byte;
        logic [31:0] sender_ip;
        logic [9:0]  slot_index;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] opcode;
        logic [9:0]  dmx_slots;
        logic        poll_reply;
        logic [7:0]  universe_now;
        logic [7:0]  slot_value;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_JUDGE,
        ST_READ
    } t_state;

endpackage

/* hw/rtl/artnet_dmx_receiver_top.sv */
// ----------------------------------------------------------------------------
// artnet_dmx_receiver_top
// ArtDmx receiver: packet byte store, packet verdict and slot level reads.
// ----------------------------------------------------------------------------
// Payload bytes are taken one per cycle while the block is idle and written
// into a single-port byte store; the last byte of a packet starts the verdict,
// and a slot read goes through the store's one registered read port before
// its answer is loaded. A result waits in the output register while further
// bytes come in; the block stalls its input while it judges a packet or
// answers a slot read, and longer while that result cannot be placed
// there. The store is zeroed after reset, and an ArtAddress clear-levels
// command zeroes it from address 18 upward; input is stalled meanwhile.
// ----------------------------------------------------------------------------
module artnet_dmx_receiver_top #(
    parameter int STORE_BYTES = artdmx_pkg::STORE_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  artdmx_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output artdmx_pkg::t_out_word o_out_word,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_wdata
);
    import artdmx_pkg::*;

    localparam int ADDR_W    = $clog2(STORE_BYTES);
    localparam int CNT_W     = $clog2(STORE_BYTES + 1);
    localparam int HDR_IDX_W = $clog2(HDR_BYTES);
    localparam int RA_W      = 11;

    // State
    t_state              r_state, n_state;
    logic [7:0]          r_mem [STORE_BYTES];
    logic [7:0]          r_rd_data;
    logic                r_rd_zero;
    logic [CNT_W-1:0]    r_byte_cnt;
    logic [ADDR_W-1:0]   r_wipe_addr;
    logic [31:0]         r_lock;
    logic [31:0]         r_ip;
    logic [9:0]          r_slot_cnt;
    logic [7:0]          r_univ;
    logic [7:0]          r_hdr [HDR_BYTES];
    logic [7:0]          r_sh_univ;
    logic [7:0]          r_sh_net;
    logic [7:0]          r_sh_cmd;
    logic                r_out_valid;
    t_out_word           r_out_word;

    // Handshake and control
    logic                acc;
    logic                acc_byte;
    logic                acc_slot;
    logic                out_free;
    logic                judge_go;
    logic                read_go;
    logic                wipe_done;
    logic                store_room;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          wr_data;
    logic [RA_W-1:0]     rd_full;
    logic                rd_in_range;

    // Verdict
    logic                id_ok;
    logic                vers_ok;
    logic [15:0]         op;
    logic [15:0]         len;
    logic [15:0]         room;
    logic [15:0]         j_op;
    logic                j_poll;
    logic [9:0]          j_slots;
    logic [7:0]          j_univ;
    logic [31:0]         j_lock;
    logic                j_wipe;

    assign acc       = i_in_valid && !o_in_stall;
    assign acc_byte  = acc && (i_in_word.req_type == REQ_BYTE);
    assign acc_slot  = acc && (i_in_word.req_type == REQ_SLOT);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign wipe_done = (r_wipe_addr == ADDR_W'(STORE_BYTES - 1));
    assign store_room = (r_byte_cnt < CNT_W'(STORE_BYTES));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_WIPE: begin
                if (wipe_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc_slot) begin
                    n_state = ST_READ;
                end else if (acc_byte && i_in_word.last_byte) begin
                    n_state = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                if (out_free) n_state = j_wipe ? ST_WIPE : ST_IDLE;
            end
            ST_READ: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_WIPE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        judge_go   = 1'b0;
        read_go    = 1'b0;
        unique case (r_state)
            ST_WIPE:  o_in_stall = 1'b1;
            ST_IDLE:  o_in_stall = 1'b0;
            ST_JUDGE: judge_go   = out_free;
            ST_READ:  read_go    = out_free;
            default:  o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WIPE;
        end else begin
            r_state <= n_state;
        end
    end

    // Store write port: incoming bytes, or zeros during a wipe pass
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_byte_cnt[ADDR_W-1:0];
        wr_data = i_in_word.packet_byte;
        if (r_state == ST_WIPE) begin
            wr_en   = 1'b1;
            wr_addr = r_wipe_addr;
            wr_data = 8'h00;
        end else if (acc_byte && store_room) begin
            wr_en = 1'b1;
        end
    end

    // Slot read address, out-of-store reads answer zero
    assign rd_full     = RA_W'(SLOT_OFFSET) + RA_W'(i_in_word.slot_index);
    assign rd_in_range = (rd_full < RA_W'(STORE_BYTES));

    // Store memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (acc_slot && rd_in_range) begin
            r_rd_data <= r_mem[rd_full[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_slot) begin
            r_rd_zero <= !rd_in_range;
        end
    end

    // Judge the packet from the mirrored header and command bytes
    always_comb begin
        id_ok = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (r_hdr[k] != ART_ID[63 - 8*k -: 8]) id_ok = 1'b0;
        end
        op      = {r_hdr[9], r_hdr[8]};
        vers_ok = (r_hdr[VERS_BYTE] >= VERSION_MIN);
        len     = {r_hdr[LENH_BYTE], r_hdr[LENL_BYTE]};
        room    = 16'(r_byte_cnt) - 16'(DMX_HDR_LEN);

        j_op    = OP_NONE;
        j_poll  = 1'b0;
        j_slots = '0;
        j_univ  = r_univ;
        j_lock  = r_lock;
        j_wipe  = 1'b0;

        if (id_ok) begin
            j_op = op;
            case (op)
                OP_DMX: begin
                    if (r_hdr[UNIV_FIELD] == r_univ && vers_ok &&
                        r_byte_cnt >= CNT_W'(DMX_HDR_LEN) && room >= len) begin
                        if (r_lock == 32'h0) j_lock = r_ip;
                        if (r_lock == 32'h0 || r_lock == r_ip) j_slots = len[9:0];
                    end
                    if (j_slots == '0) j_op = OP_NONE;
                end
                OP_ADDRESS: begin
                    if (r_byte_cnt >= CNT_W'(ADDR_MIN_LEN) && vers_ok) begin
                        if (r_sh_univ != NIB_KEEP && r_sh_univ[7]) begin
                            j_univ[3:0] = {1'b0, r_sh_univ[2:0]};
                        end
                        if (r_sh_net != NIB_KEEP && r_sh_net[7]) begin
                            j_univ[7:4] = {1'b0, r_sh_net[2:0]};
                        end
                        if (r_sh_cmd == CMD_UNLOCK) begin
                            j_lock = 32'h0;
                        end else if (r_sh_cmd == CMD_CLEAR) begin
                            j_lock  = 32'h0;
                            j_slots = SLOTS_FULL;
                            j_op    = OP_DMX;
                            j_wipe  = 1'b1;
                        end
                        j_poll = 1'b1;
                    end
                end
                OP_POLL: begin
                    if (r_byte_cnt >= CNT_W'(POLL_MIN_LEN) && vers_ok) j_poll = 1'b1;
                end
                default: j_op = op;
            endcase
        end
    end

    // Byte count, sender capture and wipe address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt  <= '0;
            r_wipe_addr <= '0;
        end else begin
            if (judge_go) begin
                r_byte_cnt <= '0;
            end else if (acc_byte && store_room) begin
                r_byte_cnt <= r_byte_cnt + CNT_W'(1);
            end
            if (judge_go && j_wipe) begin
                r_wipe_addr <= ADDR_W'(WIPE_FROM);
            end else if (r_state == ST_WIPE && !wipe_done) begin
                r_wipe_addr <= r_wipe_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_byte && i_in_word.last_byte) begin
            r_ip <= i_in_word.sender_ip;
        end
    end

    // Mirror the bytes the verdict looks at; the wipe clears those above 18
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HDR_BYTES; k++) r_hdr[k] <= 8'h00;
            r_sh_univ <= 8'h00;
            r_sh_net  <= 8'h00;
            r_sh_cmd  <= 8'h00;
        end else if (judge_go && j_wipe) begin
            r_sh_univ <= 8'h00;
            r_sh_net  <= 8'h00;
            r_sh_cmd  <= 8'h00;
        end else if (acc_byte && store_room) begin
            if (r_byte_cnt < CNT_W'(HDR_BYTES)) begin
                r_hdr[r_byte_cnt[HDR_IDX_W-1:0]] <= i_in_word.packet_byte;
            end
            if (r_byte_cnt == CNT_W'(ADDR_UNIV)) r_sh_univ <= i_in_word.packet_byte;
            if (r_byte_cnt == CNT_W'(ADDR_NET))  r_sh_net  <= i_in_word.packet_byte;
            if (r_byte_cnt == CNT_W'(ADDR_CMD))  r_sh_cmd  <= i_in_word.packet_byte;
        end
    end

    // Universe, sender lock and slot count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_univ     <= 8'h00;
            r_lock     <= 32'h0;
            r_slot_cnt <= '0;
        end else if (judge_go) begin
            r_univ     <= j_univ;
            r_lock     <= j_lock;
            r_slot_cnt <= j_slots;
        end else if (i_cfg_we) begin
            r_univ <= i_cfg_wdata;
        end
    end

    // Output register: load a verdict or a slot answer, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (judge_go || read_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (judge_go) begin
            r_out_word.result_kind  <= KIND_VERDICT;
            r_out_word.opcode       <= j_op;
            r_out_word.dmx_slots    <= j_slots;
            r_out_word.poll_reply   <= j_poll;
            r_out_word.universe_now <= j_univ;
            r_out_word.slot_value   <= 8'h00;
        end else if (read_go) begin
            r_out_word.result_kind  <= KIND_SLOT;
            r_out_word.opcode       <= OP_NONE;
            r_out_word.dmx_slots    <= r_slot_cnt;
            r_out_word.poll_reply   <= 1'b0;
            r_out_word.universe_now <= r_univ;
            r_out_word.slot_value   <= r_rd_zero ? 8'h00 : r_rd_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
